// ===== hw/rtl/pte_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Page table engine package
// Shared field widths, entry layout, operation and status codes, sequencer
// states and the virtual address index split for the four-level walk.
// ----------------------------------------------------------------------------
package pte_pkg;

	localparam int VA_W      = 48;
	localparam int PA_W      = 52;
	localparam int FLAG_W    = 12;
	localparam int ENTRY_W   = 52;
	localparam int IDX_W     = 9;
	localparam int ENTRIES   = 512;
	localparam int OFF_W     = 12;
	localparam int FRAME_W   = ENTRY_W - OFF_W;
	localparam int LVL_W     = 2;

	// Entry flag bit positions.
	localparam int BIT_PRESENT = 0;
	localparam int BIT_USER    = 2;

	// Flags of an intermediate entry before the user bit is merged in:
	// present and write.
	localparam logic [FLAG_W-1:0] MID_FLAGS = 12'h003;

	localparam logic [LVL_W-1:0] LEAF_LVL = 2'd3;

	typedef enum logic [1:0] {
		FN_MAP   = 2'd0,
		FN_UNMAP = 2'd1,
		FN_XLAT  = 2'd2,
		FN_NOP   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_MISS = 2'd1,
		ST_POOL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_WALK,
		S_DONE
	} state_t;

	// Table index for one level of the walk, level 0 being the root.
	function automatic logic [IDX_W-1:0] level_idx(
		input logic [VA_W-1:0]  va,
		input logic [LVL_W-1:0] lvl
	);
		logic [IDX_W-1:0] idx;
		unique case (lvl)
			2'd0: idx = va[47:39];
			2'd1: idx = va[38:30];
			2'd2: idx = va[29:21];
			default: idx = va[20:12];
		endcase
		return idx;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/four_level_page_table_engine_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Four-level page table engine
// Holds one four-level translation tree in an internal table store and
// serves map, unmap and translate requests against it, one item at a time.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake              Payload
//  -------  ---------  ---------------------  ------------------------------
//  in       sink       in_valid / in_stall    func, virt, phys, flags
//  out      source     out_valid / out_stall  phys_out, status
//
// An item is accepted in the cycle in which the root entry is read; the
// walk then reads one entry per level through the table store's read port,
// down to the leaf, and stops early on a missing level. The unused
// operation code walks no levels and goes straight to the final state.
// After reset the whole store is swept to zero, one entry a cycle, over
// all NUM_TABLES * 512 entries; in_stall stays high during the sweep.
// A result that is not taken holds the engine in its final state, so input
// items are stalled until the result register is free again.
//
module four_level_page_table_engine_core #(
	parameter int NUM_TABLES = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,

	input  wire logic                         in_valid,
	output      logic                         in_stall,
	input  wire logic [1:0]                   func,
	input  wire logic [pte_pkg::VA_W-1:0]     virt,
	input  wire logic [pte_pkg::PA_W-1:0]     phys,
	input  wire logic [pte_pkg::FLAG_W-1:0]   flags,

	output      logic                         out_valid,
	input  wire logic                         out_stall,
	output      logic [pte_pkg::PA_W-1:0]     phys_out,
	output      logic [1:0]                   status
);
	import pte_pkg::*;

	// Table page numbers and store addresses. The page number sits directly
	// above the entry index, so an address is a plain concatenation.
	localparam int PW    = $clog2(NUM_TABLES);
	localparam int UW    = $clog2(NUM_TABLES + 1);
	localparam int AW    = PW + IDX_W;
	localparam int DEPTH = NUM_TABLES * ENTRIES;

	// Table store: one write port and one registered read port.
	logic [ENTRY_W-1:0] mem [DEPTH];
	logic [ENTRY_W-1:0] rd_data_q;

	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [ENTRY_W-1:0] wr_data;

	// Sequencer and walk state.
	state_t        state_q;
	state_t        state_d;
	logic [LVL_W-1:0] lvl_q;
	logic [PW-1:0] page_q;
	logic [UW-1:0] used_q;
	logic [AW-1:0] clr_q;

	// The item being worked on.
	func_t              func_q;
	logic [VA_W-1:0]    virt_q;
	logic [PA_W-1:0]    phys_q;
	logic [FLAG_W-1:0]  flags_q;

	// Result held while the output register is still occupied.
	logic [PA_W-1:0]    res_q;
	status_t            rst_q;

	// Output register.
	logic               out_valid_q;
	logic [PA_W-1:0]    phys_out_q;
	status_t            status_q;

	// Decisions taken while walking.
	logic               accept;
	logic               out_free;
	logic               clr_last;
	logic               go_on;
	logic               alloc;
	logic               finish;
	logic               load_out;
	logic [PW-1:0]      next_page;
	logic [PA_W-1:0]    res;
	status_t            res_st;
	logic [PA_W-1:0]    load_phys;
	status_t            load_st;

	// Fields of the entry just read.
	logic               e_present;
	logic [FRAME_W-1:0] e_frame;
	logic               e_ptr_ok;
	logic [AW-1:0]      cur_addr;
	logic [FLAG_W-1:0]  mid_flags;

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign clr_last = (clr_q == AW'(DEPTH - 1));

	assign e_present = rd_data_q[BIT_PRESENT];
	assign e_frame   = rd_data_q[ENTRY_W-1:OFF_W];
	// A pointer beyond the pool cannot be followed; it counts as absent.
	assign e_ptr_ok  = e_present && (e_frame < FRAME_W'(NUM_TABLES));
	assign cur_addr  = {page_q, level_idx(virt_q, lvl_q)};
	assign mid_flags = MID_FLAGS | (flags_q & FLAG_W'(1 << BIT_USER));

	// ------------------------------------------------------------------
	// Next state.
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					state_d = (func_t'(func) == FN_NOP) ? S_DONE : S_WALK;
				end
			end
			S_WALK: begin
				if (finish) begin
					state_d = out_free ? S_IDLE : S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

	// ------------------------------------------------------------------
	// Walk decisions and table store controls.
	// ------------------------------------------------------------------
	always_comb begin
		in_stall  = (state_q != S_IDLE);
		rd_en     = 1'b0;
		rd_addr   = {PW'(0), level_idx(virt, 2'd0)};
		wr_en     = 1'b0;
		wr_addr   = cur_addr;
		wr_data   = '0;
		go_on     = 1'b0;
		alloc     = 1'b0;
		finish    = 1'b0;
		next_page = e_frame[PW-1:0];
		res       = '0;
		res_st    = ST_DONE;

		unique case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
			end
			S_IDLE: begin
				// The root entry is read in the cycle the item is taken.
				rd_en = accept;
			end
			S_WALK: begin
				if (lvl_q != LEAF_LVL) begin
					if (e_ptr_ok) begin
						go_on = 1'b1;
					end else if (func_q == FN_MAP) begin
						if (used_q >= UW'(NUM_TABLES)) begin
							// Pool exhausted: levels made so far stay.
							finish = 1'b1;
							res_st = ST_POOL;
						end else begin
							// Take the next page from the bump allocator. It
							// has never been used since the sweep, so it reads
							// as zero without a clearing pass of its own.
							alloc     = 1'b1;
							go_on     = 1'b1;
							next_page = used_q[PW-1:0];
							wr_en     = 1'b1;
							wr_data   = {FRAME_W'(used_q), mid_flags};
						end
					end else begin
						finish = 1'b1;
						res_st = ST_MISS;
					end
					rd_en   = go_on;
					rd_addr = {next_page, level_idx(virt_q, lvl_q + 2'd1)};
				end else begin
					finish = 1'b1;
					unique case (func_q)
						FN_MAP: begin
							wr_en   = 1'b1;
							wr_data = {phys_q[PA_W-1:OFF_W],
								flags_q | FLAG_W'(1 << BIT_PRESENT)};
						end
						FN_UNMAP: begin
							// The leaf is cleared even when it was not present.
							wr_en = 1'b1;
							if (!e_present) begin
								res_st = ST_MISS;
							end
						end
						FN_XLAT: begin
							if (e_present) begin
								res = {e_frame, virt_q[OFF_W-1:0]};
							end else begin
								res_st = ST_MISS;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase

		load_out  = (state_q == S_WALK && finish && out_free) ||
			(state_q == S_DONE && out_free);
		load_phys = (state_q == S_DONE) ? res_q : res;
		load_st   = (state_q == S_DONE) ? rst_q : res_st;
	end

	// ------------------------------------------------------------------
	// Table store.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// ------------------------------------------------------------------
	// Control registers.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			used_q      <= UW'(1);
			lvl_q       <= '0;
			page_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (accept) begin
				lvl_q  <= '0;
				page_q <= '0;
			end else if (go_on) begin
				lvl_q  <= lvl_q + 2'd1;
				page_q <= next_page;
			end
			if (alloc) begin
				used_q <= used_q + UW'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Item, held result and output payload registers.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= func_t'(func);
			virt_q  <= virt;
			phys_q  <= phys;
			flags_q <= flags;
			// The unused operation code changes nothing and reports done.
			res_q   <= '0;
			rst_q   <= ST_DONE;
		end else if (state_q == S_WALK && finish && !out_free) begin
			res_q <= res;
			rst_q <= res_st;
		end
		if (load_out) begin
			phys_out_q <= load_phys;
			status_q   <= load_st;
		end
	end

	assign out_valid = out_valid_q;
	assign phys_out  = phys_out_q;
	assign status    = status_q;

endmodule
`default_nettype wire
